// ----- src/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared widths, constants, sector codes and stage payload types for the
// HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int unsigned InW   = 13;  // hue, saturation, brightness
  localparam int unsigned RemW  = 10;  // remainder within a sector, 0..959
  localparam int unsigned SecW  = 3;   // sector 0..5
  localparam int unsigned FracW = 22;  // channel fraction, scaled by 4096*960
  localparam int unsigned ProdW = 34;  // brightness times channel fraction
  localparam int unsigned ChW   = 8;

  localparam logic [InW-1:0]   HueFull   = 13'd5760;
  localparam logic [RemW-1:0]  HueSector = 10'd960;
  localparam logic [InW-1:0]   Q12One    = 13'd4096;
  localparam logic [FracW-1:0] FracOne   = 22'd3932160;  // 4096 * 960
  localparam logic [ChW-1:0]   ChMax     = 8'd255;

  // Colour-wheel sectors, 60 degrees each
  localparam logic [SecW-1:0] SecRedYel = 3'd0;
  localparam logic [SecW-1:0] SecYelGrn = 3'd1;
  localparam logic [SecW-1:0] SecGrnCyn = 3'd2;
  localparam logic [SecW-1:0] SecCynBlu = 3'd3;
  localparam logic [SecW-1:0] SecBluMag = 3'd4;
  localparam logic [SecW-1:0] SecMagRed = 3'd5;

  typedef struct packed {
    logic [SecW-1:0] sector;
    logic [RemW-1:0] rem;
    logic [InW-1:0]  sat;
    logic [InW-1:0]  val;
  } split_t;

  typedef struct packed {
    logic [InW-1:0]   val;
    logic [FracW-1:0] red;
    logic [FracW-1:0] green;
    logic [FracW-1:0] blue;
  } mix_t;

endpackage

// ----- src/hsv_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// HSV pixel to 8-bit RGB, six-stage pipeline, one item per clock while the output is not stalled.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------------
//   in      | sink      | in_valid_i / in_ready_o  | hue_i, saturation_i, brightness_i
//   out     | source    | out_valid_o / out_ready_i| red_o, green_o, blue_o
//
// One item per cycle sustained while out_ready_i stays high; the six register
// stages (clamp/wrap, sector split, products, select, brightness multiply,
// scale) lie between acceptance and out_valid_o.
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage holds while its successor is full and stalled, so an empty
// stage keeps filling under backpressure; in_ready_o drops only once every
// stage holds an item.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hsv2rgb_pkg::InW-1:0]   hue_i,
  input  logic [hsv2rgb_pkg::InW-1:0]   saturation_i,
  input  logic [hsv2rgb_pkg::InW-1:0]   brightness_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hsv2rgb_pkg::ChW-1:0]   red_o,
  output logic [hsv2rgb_pkg::ChW-1:0]   green_o,
  output logic [hsv2rgb_pkg::ChW-1:0]   blue_o
);

  // Sector split -> blend
  logic                 split_valid;
  logic                 split_ready;
  hsv2rgb_pkg::split_t  split;

  // Blend -> scale
  logic                 mix_valid;
  logic                 mix_ready;
  hsv2rgb_pkg::mix_t    mix;

  // Stages 1-2: clamp, hue wrap, sector and remainder
  hsv2rgb_sector u_sector (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .hue_i   (hue_i),
    .sat_i   (saturation_i),
    .val_i   (brightness_i),
    .valid_o (split_valid),
    .ready_i (split_ready),
    .data_o  (split)
  );

  // Stages 3-4: p/q/t and the sector select. Zero saturation needs no
  // special path: p, q and t all come out as 1.0 and every channel follows v.
  hsv2rgb_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (split_valid),
    .ready_o (split_ready),
    .data_i  (split),
    .valid_o (mix_valid),
    .ready_i (mix_ready),
    .data_o  (mix)
  );

  // Stages 5-6: v * fraction, then * 255 / (4096 * 4096 * 960)
  hsv2rgb_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mix_valid),
    .ready_o (mix_ready),
    .data_i  (mix),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

`ifndef SYNTHESIS
  // Backpressure only ever starts at the output
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a stalled result");

  // Sector split stays inside one 60 degree sector
  a_split_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    split_valid |-> (split.rem < hsv2rgb_pkg::HueSector &&
                     split.sector <= hsv2rgb_pkg::SecMagRed))
    else $error("sector split out of range");

  // The brightest channel always carries the full fraction
  a_max_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mix_valid |-> (mix.red == hsv2rgb_pkg::FracOne ||
                   mix.green == hsv2rgb_pkg::FracOne ||
                   mix.blue == hsv2rgb_pkg::FracOne))
    else $error("no channel at full fraction");
`endif

endmodule

// ----- src/hsv2rgb_sector.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// Two stages: clamp saturation/brightness and wrap hue, then split hue into
// sector and remainder.
// ----------------------------------------------------------------------------
module hsv2rgb_sector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [hsv2rgb_pkg::InW-1:0]   hue_i,
  input  logic [hsv2rgb_pkg::InW-1:0]   sat_i,
  input  logic [hsv2rgb_pkg::InW-1:0]   val_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output hsv2rgb_pkg::split_t           data_o
);

  logic                          a_valid_q;
  logic                          a_ready;
  logic [hsv2rgb_pkg::InW-1:0]   a_hue_q, a_hue_d;
  logic [hsv2rgb_pkg::InW-1:0]   a_sat_q, a_sat_d;
  logic [hsv2rgb_pkg::InW-1:0]   a_val_q, a_val_d;
  logic                          b_valid_q;
  logic                          b_ready;
  hsv2rgb_pkg::split_t           b_q, b_d;
  logic [hsv2rgb_pkg::InW-1:0]   base;

  assign a_ready = !a_valid_q || b_ready;
  assign b_ready = !b_valid_q || ready_i;
  assign ready_o = a_ready;
  assign valid_o = b_valid_q;
  assign data_o  = b_q;

  // Stage A: saturate fractions at 1.0, wrap hue modulo 360 degrees
  always_comb begin
    a_sat_d = (sat_i > hsv2rgb_pkg::Q12One) ? hsv2rgb_pkg::Q12One : sat_i;
    a_val_d = (val_i > hsv2rgb_pkg::Q12One) ? hsv2rgb_pkg::Q12One : val_i;
    a_hue_d = (hue_i >= hsv2rgb_pkg::HueFull) ? hue_i - hsv2rgb_pkg::HueFull : hue_i;
  end

  // Stage B: hue / 960 by comparison against sector boundaries
  always_comb begin
    if (a_hue_q >= 13'd4800) begin
      b_d.sector = hsv2rgb_pkg::SecMagRed;
      base       = 13'd4800;
    end else if (a_hue_q >= 13'd3840) begin
      b_d.sector = hsv2rgb_pkg::SecBluMag;
      base       = 13'd3840;
    end else if (a_hue_q >= 13'd2880) begin
      b_d.sector = hsv2rgb_pkg::SecCynBlu;
      base       = 13'd2880;
    end else if (a_hue_q >= 13'd1920) begin
      b_d.sector = hsv2rgb_pkg::SecGrnCyn;
      base       = 13'd1920;
    end else if (a_hue_q >= 13'd960) begin
      b_d.sector = hsv2rgb_pkg::SecYelGrn;
      base       = 13'd960;
    end else begin
      b_d.sector = hsv2rgb_pkg::SecRedYel;
      base       = 13'd0;
    end
    b_d.rem = hsv2rgb_pkg::RemW'(a_hue_q - base);
    b_d.sat = a_sat_q;
    b_d.val = a_val_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      a_hue_q <= a_hue_d;
      a_sat_q <= a_sat_d;
      a_val_q <= a_val_d;
    end
    if (b_ready && a_valid_q) begin
      b_q <= b_d;
    end
  end

endmodule

// ----- src/hsv2rgb_blend.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_blend
// Two stages: products for p, q and t, then subtraction and the six-way
// sector select onto red, green and blue fractions.
// ----------------------------------------------------------------------------
module hsv2rgb_blend (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  hsv2rgb_pkg::split_t  data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output hsv2rgb_pkg::mix_t    data_o
);

  logic                            a_valid_q;
  logic                            a_ready;
  logic [hsv2rgb_pkg::FracW-1:0]   a_sr_q, a_sr_d;  // s * r
  logic [hsv2rgb_pkg::FracW-1:0]   a_st_q, a_st_d;  // s * (960 - r)
  logic [hsv2rgb_pkg::FracW-1:0]   a_np_q, a_np_d;  // (1 - s), scaled
  logic [hsv2rgb_pkg::SecW-1:0]    a_sec_q;
  logic [hsv2rgb_pkg::InW-1:0]     a_val_q;
  logic                            b_valid_q;
  logic                            b_ready;
  hsv2rgb_pkg::mix_t               b_q, b_d;
  logic [hsv2rgb_pkg::RemW-1:0]    rem_inv;
  logic [hsv2rgb_pkg::InW-1:0]     sat_inv;
  logic [hsv2rgb_pkg::FracW-1:0]   nq, nt;

  assign a_ready = !a_valid_q || b_ready;
  assign b_ready = !b_valid_q || ready_i;
  assign ready_o = a_ready;
  assign valid_o = b_valid_q;
  assign data_o  = b_q;

  // All three products stay within 4096 * 960
  always_comb begin
    rem_inv = hsv2rgb_pkg::HueSector - data_i.rem;
    sat_inv = hsv2rgb_pkg::Q12One - data_i.sat;
    a_sr_d  = hsv2rgb_pkg::FracW'(data_i.sat * data_i.rem);
    a_st_d  = hsv2rgb_pkg::FracW'(data_i.sat * rem_inv);
    a_np_d  = hsv2rgb_pkg::FracW'(sat_inv * hsv2rgb_pkg::HueSector);
  end

  always_comb begin
    nq      = hsv2rgb_pkg::FracOne - a_sr_q;
    nt      = hsv2rgb_pkg::FracOne - a_st_q;
    b_d.val = a_val_q;
    case (a_sec_q)
      hsv2rgb_pkg::SecRedYel: begin
        b_d.red = hsv2rgb_pkg::FracOne; b_d.green = nt; b_d.blue = a_np_q;
      end
      hsv2rgb_pkg::SecYelGrn: begin
        b_d.red = nq; b_d.green = hsv2rgb_pkg::FracOne; b_d.blue = a_np_q;
      end
      hsv2rgb_pkg::SecGrnCyn: begin
        b_d.red = a_np_q; b_d.green = hsv2rgb_pkg::FracOne; b_d.blue = nt;
      end
      hsv2rgb_pkg::SecCynBlu: begin
        b_d.red = a_np_q; b_d.green = nq; b_d.blue = hsv2rgb_pkg::FracOne;
      end
      hsv2rgb_pkg::SecBluMag: begin
        b_d.red = nt; b_d.green = a_np_q; b_d.blue = hsv2rgb_pkg::FracOne;
      end
      default: begin
        b_d.red = hsv2rgb_pkg::FracOne; b_d.green = a_np_q; b_d.blue = nq;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      a_sr_q  <= a_sr_d;
      a_st_q  <= a_st_d;
      a_np_q  <= a_np_d;
      a_sec_q <= data_i.sector;
      a_val_q <= data_i.val;
    end
    if (b_ready && a_valid_q) begin
      b_q <= b_d;
    end
  end

endmodule

// ----- src/hsv2rgb_scale.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_scale
// Two stages: brightness times channel fraction, then times 255 over the
// full scale, which reduces to (17 * x) >> 30, saturated at 255.
// ----------------------------------------------------------------------------
module hsv2rgb_scale (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  hsv2rgb_pkg::mix_t             data_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [hsv2rgb_pkg::ChW-1:0]   red_o,
  output logic [hsv2rgb_pkg::ChW-1:0]   green_o,
  output logic [hsv2rgb_pkg::ChW-1:0]   blue_o
);

  localparam int unsigned WideW = hsv2rgb_pkg::ProdW + 5;
  localparam int unsigned Shift = 30;

  logic                              a_valid_q;
  logic                              a_ready;
  logic [hsv2rgb_pkg::ProdW-1:0]     a_r_q, a_g_q, a_b_q;
  logic                              b_valid_q;
  logic                              b_ready;
  logic [hsv2rgb_pkg::ChW-1:0]       b_r_q, b_g_q, b_b_q;
  logic [hsv2rgb_pkg::ChW-1:0]       b_r_d, b_g_d, b_b_d;

  assign a_ready = !a_valid_q || b_ready;
  assign b_ready = !b_valid_q || ready_i;
  assign ready_o = a_ready;
  assign valid_o = b_valid_q;
  assign red_o   = b_r_q;
  assign green_o = b_g_q;
  assign blue_o  = b_b_q;

  function automatic logic [hsv2rgb_pkg::ChW-1:0] to_chan(
    input logic [hsv2rgb_pkg::ProdW-1:0] x
  );
    logic [WideW-1:0]  w;
    logic [WideW-Shift-1:0] c;
    w = {x, 4'b0000} + {5'b00000, x};
    c = w[WideW-1:Shift];
    to_chan = (c > {1'b0, hsv2rgb_pkg::ChMax}) ? hsv2rgb_pkg::ChMax
                                               : hsv2rgb_pkg::ChW'(c);
  endfunction

  always_comb begin
    b_r_d = to_chan(a_r_q);
    b_g_d = to_chan(a_g_q);
    b_b_d = to_chan(a_b_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      a_r_q <= hsv2rgb_pkg::ProdW'(data_i.val * data_i.red);
      a_g_q <= hsv2rgb_pkg::ProdW'(data_i.val * data_i.green);
      a_b_q <= hsv2rgb_pkg::ProdW'(data_i.val * data_i.blue);
    end
    if (b_ready && a_valid_q) begin
      b_r_q <= b_r_d;
      b_g_q <= b_g_d;
      b_b_q <= b_b_d;
    end
  end

endmodule
